[rtl/core/hpc_pkg.sv]
package hpc_pkg;

    typedef enum logic [1:0] {
        KIND_WIDEN_HALF  = 2'd0,
        KIND_WIDEN_BF16  = 2'd1,
        KIND_NARROW_HALF = 2'd2,
        KIND_UNUSED      = 2'd3
    } kind_t;

    localparam logic [31:0] INF32   = 32'h7F80_0000;
    localparam logic [15:0] INF16   = 16'h7C00;
    localparam logic [15:0] QNAN16  = 16'h0200;
    localparam logic [12:0] LOWHALF = 13'h1000;
    localparam logic [4:0]  EXP16   = 5'h1F;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] operand;
    } item_t;

    typedef struct packed {
        logic [31:0] result;
        logic        exact;
    } res_t;

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [31:0] sign;
        logic [4:0]  e;
        logic [9:0]  m;
        logic [3:0]  p;
        logic [22:0] mm;
        logic [7:0]  ee;
        sign = {h[15], 31'd0};
        e = h[14:10];
        m = h[9:0];
        p = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (m[i])
            begin
                p = 4'(i);
            end
        end
        mm = 23'({13'd0, m} << (5'd23 - {1'b0, p}));
        ee = 8'(p) + 8'd103;
        if (e == EXP16)
        begin
            widen_half = sign | INF32 | {9'd0, m, 13'd0};
        end
        else if (e == 5'd0)
        begin
            widen_half = (m == 10'd0) ? sign : (sign | {1'b0, ee, mm});
        end
        else
        begin
            widen_half = sign | {1'b0, 8'(e) + 8'd112, m, 13'd0};
        end
    endfunction

endpackage

[rtl/core/hpc_stream_if.sv]
interface hpc_stream_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/hpc_narrow.sv]
module hpc_narrow (
    input  logic [31:0] f,
    output logic [15:0] h
);
    import hpc_pkg::*;

    logic [7:0]  raw;
    logic [22:0] m;
    logic [23:0] full;
    logic [4:0]  sh;
    logic [23:0] kept;
    logic [23:0] dropped;
    logic [23:0] halfbit;
    logic        up;
    logic [14:0] nrm;
    logic        nup;

    always_comb
    begin
        raw = f[30:23];
        m = f[22:0];
        full = {1'b1, m};
        sh = 5'(8'd126 - raw);
        kept = full >> sh;
        halfbit = 24'd1 << (sh - 5'd1);
        dropped = full & ((24'd1 << sh) - 24'd1);
        up = ((dropped & halfbit) != 24'd0)
            && (((dropped & (halfbit - 24'd1)) != 24'd0) || kept[0]);
        nup = m[12] && ((m[11:0] != 12'd0) || m[13]);
        nrm = {5'(raw - 8'd112), m[22:13]} + {14'd0, nup};
        if (raw == 8'hFF)
        begin
            h = {f[31], 15'd0} | INF16 | ((m != 23'd0) ? QNAN16 : 16'd0);
        end
        else if (raw >= 8'd143)
        begin
            h = {f[31], 15'd0} | INF16;
        end
        else if (raw < 8'd102)
        begin
            h = {f[31], 15'd0};
        end
        else if (raw <= 8'd112)
        begin
            h = {f[31], 15'(kept) + {14'd0, up}};
        end
        else
        begin
            h = {f[31], nrm};
        end
    end
endmodule

[rtl/core/hpc_datapath.sv]
module hpc_datapath (
    input  hpc_pkg::item_t item,
    output hpc_pkg::res_t  res
);
    import hpc_pkg::*;

    logic [15:0] h;
    logic [31:0] back;
    logic        nan;

    hpc_narrow u_narrow (.f(item.operand), .h(h));

    always_comb
    begin
        back = widen_half(h);
        nan = (item.operand[30:23] == 8'hFF) && (item.operand[22:0] != 23'd0);
        res = '0;
        case (kind_t'(item.kind))
            KIND_WIDEN_HALF:
            begin
                res.result = widen_half(item.operand[15:0]);
                res.exact = 1'b1;
            end
            KIND_WIDEN_BF16:
            begin
                res.result = {item.operand[15:0], 16'd0};
                res.exact = 1'b1;
            end
            KIND_NARROW_HALF:
            begin
                res.result = {16'd0, h};
                res.exact = !nan && ((((back | item.operand) & 32'h7FFF_FFFF) == 32'd0)
                    || (back == item.operand));
            end
            default:
            begin
                res = '0;
            end
        endcase
    end
endmodule

[rtl/core/half_precision_converter.sv]
// An accepted result goes to the main result register, or to the skid one
// while main is held. Throughput: one item per cycle without output stalls;
// input ready, a registered flag, falls once both buffer entries are full.
// Reset: rst_n is asynchronous and active low and empties the output buffer.
module half_precision_converter (
    input logic        clk,
    input logic        rst_n,
    hpc_stream_if.sink   in_ch,
    hpc_stream_if.source out_ch
);
    import hpc_pkg::*;

    item_t       item;
    res_t        res;
    res_t        main_reg;
    res_t        skid_reg;
    logic        main_v_reg;
    logic        skid_v_reg;
    logic        in_go;
    logic        out_go;

    assign item = '{kind: in_ch.data[33:32], operand: in_ch.data[31:0]};

    hpc_datapath u_dp (.item(item), .res(res));

    assign in_ch.ready = !skid_v_reg;
    assign in_go = in_ch.valid && in_ch.ready;
    assign out_go = out_ch.valid && out_ch.ready;
    assign out_ch.valid = main_v_reg;
    assign out_ch.data = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (!main_v_reg || out_go)
            begin
                main_v_reg <= skid_v_reg || in_go;
                skid_v_reg <= 1'b0;
            end
            else if (in_go)
            begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_v_reg || out_go)
        begin
            main_reg <= skid_v_reg ? skid_reg : res;
        end
        if (in_go && !((!main_v_reg || out_go) && !skid_v_reg))
        begin
            skid_reg <= res;
        end
    end

`ifndef SYNTH
    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> main_v_reg) else $error("skid entry without main entry");
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> !in_ch.ready) else $error("input ready while buffer full");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        main_v_reg && !out_ch.ready |=> main_v_reg && $stable(main_reg))
        else $error("result changed under stall");
`endif
endmodule
